>>> rtl/gyc_pkg.sv
// Shared types and constants for the gyro yaw rate command block.
// Used by gyc_div, gyc_mul and gyro_yaw_rate_command; no dependencies.
`default_nettype none

package gyc_pkg;

  localparam int GZ_W      = 16;
  localparam int SUM_W     = 27;
  localparam int CNT_W     = 10;
  localparam int DEN_W     = CNT_W + 1;
  localparam int CAL_FULL  = 1 << CNT_W;
  localparam int DVD_W     = 26;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int MAG_W     = 39;
  localparam int GAIN_W    = 32;
  localparam int MUL_DIGIT = 8;
  localparam int MUL_STEPS = GAIN_W / MUL_DIGIT;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);

  localparam int ANGLE_W   = 40;
  localparam int CMD_W     = 16;
  localparam int CMD_MAG_W = CMD_W - 1;
  localparam int CMD_ONE   = 16384;

  localparam int CFG_W     = 39;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CMD_GAIN   = 2'd3;

  localparam logic [CNT_W-1:0]  CAL_COUNT_RST  = 10'd10;
  localparam logic [MAG_W-1:0]  DEAD_ZONE_RST  = 39'd130935;
  localparam logic [MAG_W-1:0]  FULL_SCALE_RST = 39'd1178411;
  localparam logic [GAIN_W-1:0] CMD_GAIN_RST   = 32'd59714941;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_CLASSIFY,
    ST_MUL_WAIT,
    ST_WRITE
  } gyc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

>>> rtl/gyc_div.sv
// Bit-serial restoring divider for the gyro bias: rounded |sum| / n, sign restored.
// Depends on gyc_pkg.
`default_nettype none

module gyc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [gyc_pkg::SUM_W-1:0]    sum_i,
  input  wire logic        [gyc_pkg::DEN_W-1:0]    den_i,
  output gyc_pkg::unit_stat_t                      stat_o,
  output logic signed      [gyc_pkg::GZ_W-1:0]     quot_o
);

  localparam int SUM_W = gyc_pkg::SUM_W;
  localparam int DEN_W = gyc_pkg::DEN_W;
  localparam int DVD_W = gyc_pkg::DVD_W;
  localparam int GZ_W  = gyc_pkg::GZ_W;
  localparam int TRY_W = DEN_W + 1;

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [gyc_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                            neg_q, neg_d;
  logic [DEN_W-1:0]                den_q, den_d;
  logic [DEN_W-1:0]                rem_q, rem_d;
  logic [DVD_W-1:0]                dvd_q, dvd_d;

  logic [SUM_W-1:0]                sum_mag;
  logic [TRY_W-1:0]                trial;
  logic                            fits;
  logic                            last;

  always_comb begin
    sum_mag = sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
    trial   = {rem_q, dvd_q[DVD_W-1]};
    fits    = trial >= TRY_W'(den_q);
    last    = cnt_q == gyc_pkg::DIV_CNT_W'(gyc_pkg::DIV_STEPS - 1);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - TRY_W'(den_q)) : DEN_W'(trial);
      dvd_d = {dvd_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = sum_i[SUM_W-1];
      den_d  = den_i;
      rem_d  = '0;
      dvd_d  = DVD_W'(sum_mag + SUM_W'(den_i >> 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o = neg_q ? -$signed(dvd_q[GZ_W-1:0]) : $signed(dvd_q[GZ_W-1:0]);

endmodule

`default_nettype wire

>>> rtl/gyc_mul.sv
// Digit-serial multiplier for the ramp command: |yaw| * gain, 8 gain bits per cycle,
// rounded at bit 32 and clamped to one. Depends on gyc_pkg.
`default_nettype none

module gyc_mul (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [gyc_pkg::MAG_W-1:0]         mag_i,
  input  wire logic [gyc_pkg::GAIN_W-1:0]        gain_i,
  output gyc_pkg::unit_stat_t                    stat_o,
  output logic      [gyc_pkg::CMD_MAG_W-1:0]     cmd_mag_o
);

  localparam int MAG_W  = gyc_pkg::MAG_W;
  localparam int GAIN_W = gyc_pkg::GAIN_W;
  localparam int DIG_W  = gyc_pkg::MUL_DIGIT;
  localparam int HI_W   = MAG_W + 1;
  localparam int PP_W   = MAG_W + DIG_W;
  localparam int SUM_W  = PP_W + 1;
  localparam logic [HI_W-1:0] ONE_WIDE = HI_W'(gyc_pkg::CMD_ONE);

  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [gyc_pkg::MUL_CNT_W-1:0]   cnt_q, cnt_d;
  logic [MAG_W-1:0]                mag_q, mag_d;
  logic [GAIN_W-1:0]               gain_q, gain_d;
  logic [HI_W-1:0]                 hi_q, hi_d;
  logic [GAIN_W-1:0]               lo_q, lo_d;

  logic [PP_W-1:0]                 part;
  logic [SUM_W-1:0]                sum;
  logic [HI_W-1:0]                 rnd;

  always_comb begin
    part = PP_W'(mag_q) * PP_W'(gain_q[DIG_W-1:0]);
    sum  = SUM_W'(hi_q) + SUM_W'(part);

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    gain_d = gain_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (busy_q) begin
      hi_d   = sum[SUM_W-1:DIG_W];
      lo_d   = {sum[DIG_W-1:0], lo_q[GAIN_W-1:DIG_W]};
      gain_d = gain_q >> DIG_W;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == gyc_pkg::MUL_CNT_W'(gyc_pkg::MUL_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mag_d  = mag_i;
      gain_d = gain_i;
      hi_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    gain_q <= gain_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
  end

  always_comb begin
    rnd       = hi_q + HI_W'(lo_q[GAIN_W-1]);
    cmd_mag_o = (rnd > ONE_WIDE) ? ONE_WIDE[gyc_pkg::CMD_MAG_W-1:0]
                                 : rnd[gyc_pkg::CMD_MAG_W-1:0];
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

>>> rtl/gyro_yaw_rate_command.sv
// Channel  Handshake                  Beat payload
// in       in_valid_i / in_stall_o    gyro_z_i
// out      out_valid_o / out_stall_i  calibrating_o, yaw_angle_o, yaw_command_o
// cfg      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// Calibration beat: step, then write; the beat that closes calibration also runs
// the bit-serial bias divider (one quotient bit per cycle, 26 bits) before the write.
// Tracking beat: step, classify, write; the ramp adds the gain multiply (8 bits a cycle).
// A finished beat waits in the output register; a new input beat is taken meanwhile.
// Reset clears the calibration state, the accumulator and the registers to defaults.
// Top level: bias calibration, saturating yaw accumulator and command mapping.
// Depends on gyc_pkg, gyc_div, gyc_mul.
`default_nettype none

module gyro_yaw_rate_command #(
  parameter int ACCUM_WIDTH = 40
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic        [gyc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [gyc_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [gyc_pkg::GZ_W-1:0]       gyro_z_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic                                       calibrating_o,
  output logic signed      [gyc_pkg::ANGLE_W-1:0]    yaw_angle_o,
  output logic signed      [gyc_pkg::CMD_W-1:0]      yaw_command_o
);

  localparam int GZ_W      = gyc_pkg::GZ_W;
  localparam int DLT_W     = GZ_W + 1;
  localparam int SUM_W     = gyc_pkg::SUM_W;
  localparam int CNT_W     = gyc_pkg::CNT_W;
  localparam int DEN_W     = gyc_pkg::DEN_W;
  localparam int MAG_W     = gyc_pkg::MAG_W;
  localparam int GAIN_W    = gyc_pkg::GAIN_W;
  localparam int CMD_W     = gyc_pkg::CMD_W;
  localparam int ANGLE_W   = gyc_pkg::ANGLE_W;
  localparam int ACC_EXT_W = ACCUM_WIDTH + 1;
  localparam int CMP_W     = (ACCUM_WIDTH > MAG_W) ? ACCUM_WIDTH : MAG_W;
  localparam logic signed [CMD_W-1:0] CMD_ONE = CMD_W'(gyc_pkg::CMD_ONE);
  localparam logic [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

  gyc_pkg::gyc_state_e state_q, state_d;

  logic [CNT_W-1:0]               cal_count_q;
  logic [MAG_W-1:0]               dead_zone_q;
  logic [MAG_W-1:0]               full_scale_q;
  logic [GAIN_W-1:0]              cmd_gain_q;

  logic                           cal_phase_q, cal_phase_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic signed [SUM_W-1:0]        bias_sum_q, bias_sum_d;
  logic signed [GZ_W-1:0]         bias_q, bias_d;
  logic signed [ACCUM_WIDTH-1:0]  acc_q, acc_d;
  logic signed [GZ_W-1:0]         gz_q, gz_d;
  logic                           res_cal_q, res_cal_d;
  logic                           res_neg_q, res_neg_d;
  logic signed [CMD_W-1:0]        res_cmd_q, res_cmd_d;
  logic                           out_valid_q, out_valid_d;
  logic                           out_load;

  logic [DEN_W-1:0]               cnt_next;
  logic [DEN_W-1:0]               cal_target;
  logic                           cal_done;
  logic signed [DLT_W-1:0]        dlt;
  logic signed [ACC_EXT_W-1:0]    diff;
  logic                           acc_ovf;
  logic [ACCUM_WIDTH-1:0]         acc_mag;
  logic                           in_dead;
  logic                           in_sat;
  logic                           in_ramp;

  logic                           div_start;
  logic [DEN_W-1:0]               div_den;
  gyc_pkg::unit_stat_t            div_stat;
  logic signed [GZ_W-1:0]         div_quot;
  logic                           mul_start;
  gyc_pkg::unit_stat_t            mul_stat;
  logic [gyc_pkg::CMD_MAG_W-1:0]  mul_mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_count_q  <= gyc_pkg::CAL_COUNT_RST;
      dead_zone_q  <= gyc_pkg::DEAD_ZONE_RST;
      full_scale_q <= gyc_pkg::FULL_SCALE_RST;
      cmd_gain_q   <= gyc_pkg::CMD_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gyc_pkg::CFG_CAL_COUNT:  cal_count_q  <= cfg_data_i[CNT_W-1:0];
        gyc_pkg::CFG_DEAD_ZONE:  dead_zone_q  <= cfg_data_i[MAG_W-1:0];
        gyc_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_data_i[MAG_W-1:0];
        gyc_pkg::CFG_CMD_GAIN:   cmd_gain_q   <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_next   = DEN_W'(cnt_q) + 1'b1;
    cal_target = (cal_count_q == '0) ? DEN_W'(gyc_pkg::CAL_FULL) : DEN_W'(cal_count_q);
    cal_done   = cnt_next >= cal_target;
    div_den    = (cnt_q == '0) ? DEN_W'(gyc_pkg::CAL_FULL) : DEN_W'(cnt_q);

    dlt     = DLT_W'(gz_q) - DLT_W'(bias_q);
    diff    = ACC_EXT_W'(acc_q) - ACC_EXT_W'(dlt);
    acc_ovf = diff[ACCUM_WIDTH] != diff[ACCUM_WIDTH-1];

    acc_mag = acc_q[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(-acc_q) : ACCUM_WIDTH'(acc_q);
    in_dead = CMP_W'(acc_mag) < CMP_W'(dead_zone_q);
    in_sat  = CMP_W'(acc_mag) > CMP_W'(full_scale_q);
    in_ramp = !in_dead && !in_sat;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gyc_pkg::ST_IDLE:      if (in_valid_i) state_d = gyc_pkg::ST_STEP;
      gyc_pkg::ST_STEP: begin
        if (!cal_phase_q)  state_d = gyc_pkg::ST_CLASSIFY;
        else if (cal_done) state_d = gyc_pkg::ST_DIV_START;
        else               state_d = gyc_pkg::ST_WRITE;
      end
      gyc_pkg::ST_DIV_START: state_d = gyc_pkg::ST_DIV_WAIT;
      gyc_pkg::ST_DIV_WAIT:  if (div_stat.done) state_d = gyc_pkg::ST_WRITE;
      gyc_pkg::ST_CLASSIFY:  state_d = in_ramp ? gyc_pkg::ST_MUL_WAIT : gyc_pkg::ST_WRITE;
      gyc_pkg::ST_MUL_WAIT:  if (mul_stat.done) state_d = gyc_pkg::ST_WRITE;
      gyc_pkg::ST_WRITE:     if (!out_valid_q || !out_stall_i) state_d = gyc_pkg::ST_IDLE;
      default:               state_d = gyc_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall_o  = state_q != gyc_pkg::ST_IDLE;
    div_start   = state_q == gyc_pkg::ST_DIV_START;
    mul_start   = (state_q == gyc_pkg::ST_CLASSIFY) && in_ramp;
    out_load    = (state_q == gyc_pkg::ST_WRITE) && (!out_valid_q || !out_stall_i);
    out_valid_d = out_load || (out_valid_q && out_stall_i);

    gz_d        = gz_q;
    cal_phase_d = cal_phase_q;
    cnt_d       = cnt_q;
    bias_sum_d  = bias_sum_q;
    bias_d      = bias_q;
    acc_d       = acc_q;
    res_cal_d   = res_cal_q;
    res_neg_d   = res_neg_q;
    res_cmd_d   = res_cmd_q;

    unique case (state_q)
      gyc_pkg::ST_IDLE: begin
        if (in_valid_i) gz_d = gyro_z_i;
      end
      gyc_pkg::ST_STEP: begin
        res_cal_d = cal_phase_q;
        res_cmd_d = '0;
        if (cal_phase_q) begin
          bias_sum_d = bias_sum_q + SUM_W'(gz_q);
          cnt_d      = cnt_next[CNT_W-1:0];
          if (cal_done) cal_phase_d = 1'b0;
        end else begin
          acc_d = acc_ovf ? (diff[ACCUM_WIDTH] ? ACC_MIN : ACC_MAX)
                          : diff[ACCUM_WIDTH-1:0];
        end
      end
      gyc_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) bias_d = div_quot;
      end
      gyc_pkg::ST_CLASSIFY: begin
        res_neg_d = acc_q[ACCUM_WIDTH-1];
        if (in_dead)     res_cmd_d = '0;
        else if (in_sat) res_cmd_d = acc_q[ACCUM_WIDTH-1] ? -CMD_ONE : CMD_ONE;
      end
      gyc_pkg::ST_MUL_WAIT: begin
        if (mul_stat.done) begin
          res_cmd_d = res_neg_q ? -$signed(CMD_W'(mul_mag)) : $signed(CMD_W'(mul_mag));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gyc_pkg::ST_IDLE;
      cal_phase_q <= 1'b1;
      cnt_q       <= '0;
      bias_sum_q  <= '0;
      bias_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cal_phase_q <= cal_phase_d;
      cnt_q       <= cnt_d;
      bias_sum_q  <= bias_sum_d;
      bias_q      <= bias_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gz_q      <= gz_d;
    res_cal_q <= res_cal_d;
    res_neg_q <= res_neg_d;
    res_cmd_q <= res_cmd_d;
    if (out_load) begin
      calibrating_o <= res_cal_q;
      yaw_angle_o   <= ANGLE_W'(acc_q);
      yaw_command_o <= res_cmd_q;
    end
  end

  assign out_valid_o = out_valid_q;

  gyc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (bias_sum_q),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  gyc_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mag_i     (MAG_W'(acc_mag)),
    .gain_i    (cmd_gain_q),
    .stat_o    (mul_stat),
    .cmd_mag_o (mul_mag)
  );

`ifndef SYNTH
  // accumulator frozen while collecting bias samples
  a_acc_frozen_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_phase_q |=> acc_q == $past(acc_q))
    else $error("yaw accumulator moved during calibration");

  a_cal_cmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibrating_o |-> yaw_command_o == '0)
    else $error("calibration beat carries a command");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (yaw_command_o <= CMD_ONE) && (yaw_command_o >= -CMD_ONE))
    else $error("command outside +/-1.0");

  a_mul_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gyc_pkg::ST_MUL_WAIT |-> mul_stat.busy || mul_stat.done)
    else $error("waiting on idle multiplier");
`endif

endmodule

`default_nettype wire
